FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("property violated");

`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("property violated");

`else

`define ASSERT_IMPL(name, clk, rst, ante, cons)

`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/clsr_pkg.sv
`default_nettype none

package clsr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int WARM_SKIP   = 8;
  localparam int WARM_STEPS  = TABLE_DEPTH + WARM_SKIP;

  localparam int VAL_W      = 31;
  localparam int WORD_W     = VAL_W + 1;
  localparam int FSUM_W     = VAL_W + 2;
  localparam int FRAC_W     = 24;
  localparam int FRAC_SHIFT = VAL_W - FRAC_W;
  localparam int MUL_W      = 16;
  localparam int PROD_W     = VAL_W + MUL_W;
  localparam int FOLD_W     = 8;

  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EST_W  = SLOT_W + 2;
  localparam int CNT_W  = $clog2(WARM_STEPS);

  localparam logic [VAL_W:0] MOD_A      = 32'd2147483563;
  localparam logic [VAL_W:0] MOD_B      = 32'd2147483399;
  localparam logic [VAL_W:0] MOD_A_LESS = MOD_A - 32'd1;

  localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_B = 16'd40692;

  localparam logic [FOLD_W-1:0] FOLD_A = FOLD_W'((64'd1 << VAL_W) - 64'(MOD_A));
  localparam logic [FOLD_W-1:0] FOLD_B = FOLD_W'((64'd1 << VAL_W) - 64'(MOD_B));

  localparam logic [VAL_W-1:0]  GEN_TWO_INIT = 31'd123456789;
  localparam logic [FRAC_W-1:0] FRAC_MAX     = 24'd16777214;

  localparam longint SLOT_DIV   = 1 + longint'(MOD_A_LESS) / TABLE_DEPTH;
  localparam int     SLOT_SHIFT = 37;
  localparam longint SLOT_RECIP = (longint'(1) << SLOT_SHIFT) / SLOT_DIV;
  localparam int     RECIP_W    = $clog2(SLOT_RECIP + 1);
  localparam int     EPROD_W    = VAL_W + RECIP_W;
  localparam int     LIM_W      = EST_W + VAL_W;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_D0   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_D1   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_D2   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_D3   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_D4   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RS0  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RS1  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RS2  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RS3  = 4'd9;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] seed_value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]  raw_value;
    logic [FRAC_W-1:0] fraction;
  } draw_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_ONE, MUL_TWO} mul_sel_t;
  typedef enum logic [1:0] {G_HOLD, G_SEED, G_RED} gen_ld_t;
  typedef enum logic [1:0] {LAST_HOLD, LAST_GEN, LAST_DIFF} last_sel_t;
  typedef enum logic [1:0] {TW_NONE, TW_WARM, TW_SLOT} tab_wr_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INIT, CNT_DEC} cnt_op_t;
  typedef enum logic [2:0] {J_NEXT, J_ACTION, J_LOOP, J_DONE, J_ALWAYS} jump_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    gen_ld_t           g1_ld;
    gen_ld_t           g2_ld;
    logic              est_ld;
    logic              slot_ld;
    logic              rd_en;
    last_sel_t         last_sel;
    tab_wr_t           tab_wr;
    cnt_op_t           cnt_op;
    logic              out_ld;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Reduces a product of a 31-bit value and a 16-bit multiplier modulo m = 2^31 - c.
  function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                input logic [FOLD_W-1:0] c,
                                                input logic [VAL_W:0]    m);
    logic [MUL_W-1:0] hi;
    logic [VAL_W:0]   s1;
    logic [VAL_W:0]   s2;
    logic [VAL_W:0]   s3;
    hi = p[PROD_W-1:VAL_W];
    s1 = {1'b0, p[VAL_W-1:0]} + WORD_W'(hi) * WORD_W'(c);
    s2 = {1'b0, s1[VAL_W-1:0]} + (s1[VAL_W] ? WORD_W'(c) : '0);
    s3 = (s2 >= m) ? s2 - m : s2;
    return s3[VAL_W-1:0];
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_IDLE: begin
        w.jump   = J_ACTION;
        w.target = STEP_RS0;
      end
      STEP_D0: begin
        w.mul_sel = MUL_ONE;
        w.est_ld  = 1'b1;
      end
      STEP_D1: begin
        w.g1_ld   = G_RED;
        w.mul_sel = MUL_TWO;
        w.slot_ld = 1'b1;
      end
      STEP_D2: begin
        w.g2_ld = G_RED;
        w.rd_en = 1'b1;
      end
      STEP_D3: begin
        w.last_sel = LAST_DIFF;
        w.tab_wr   = TW_SLOT;
      end
      STEP_D4: begin
        w.out_ld = 1'b1;
        w.jump   = J_DONE;
        w.target = STEP_IDLE;
      end
      STEP_RS0: begin
        w.g1_ld  = G_SEED;
        w.g2_ld  = G_SEED;
        w.cnt_op = CNT_INIT;
      end
      STEP_RS1: begin
        w.mul_sel = MUL_ONE;
      end
      STEP_RS2: begin
        w.g1_ld  = G_RED;
        w.tab_wr = TW_WARM;
        w.cnt_op = CNT_DEC;
        w.jump   = J_LOOP;
        w.target = STEP_RS1;
      end
      STEP_RS3: begin
        w.last_sel = LAST_GEN;
        w.jump     = J_ALWAYS;
        w.target   = STEP_D0;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/combined_lcg_shuffle_random_core.sv
// Combined two-generator LCG with a 32-entry shuffle table. Each command
// transaction yields exactly one draw transaction carrying the raw value and a
// 24-bit fraction; a reseed first runs its 40 warm-up steps. The steps are set
// by the single 31x16 multiplier with its modular reduction, shared by both
// generators in turn, and by the one-port shuffle table read in the cycle
// before its update. Commands are taken only while the sequencer is idle; a
// finished draw waits in the output register while the next command is
// processed. After reset the table reads as zero.
`default_nettype none

module combined_lcg_shuffle_random_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  clsr_pkg::cmd_t  cmd,
  output logic            draw_valid,
  input  logic            draw_stall,
  output clsr_pkg::draw_t draw
);
  import clsr_pkg::*;

  `include "assert_macros.svh"

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;

  logic [VAL_W-1:0]  gen_one;
  logic [VAL_W-1:0]  gen_two;
  logic [VAL_W-1:0]  last;
  logic [VAL_W-1:0]  seed;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [EST_W-1:0]  est;
  logic [SLOT_W-1:0] slot;

  logic [VAL_W-1:0]       tab_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tab_valid;
  logic [VAL_W-1:0]       tab_rdata;
  logic                   rd_valid;
  logic                   tab_we;
  logic [SLOT_W-1:0]      tab_addr;
  logic [VAL_W-1:0]       tab_wdata;

  logic              accept;
  logic              blocked;
  logic              load_out;
  logic [VAL_W-1:0]  seed_fix;
  logic [VAL_W-1:0]  mul_op;
  logic [MUL_W-1:0]  mul_k;
  logic              red_b;
  logic [VAL_W-1:0]  red;
  logic [EPROD_W-1:0] est_prod;
  logic [EST_W-1:0]  est_inc;
  logic [LIM_W-1:0]  est_lim;
  logic [EST_W-1:0]  slot_raw;
  logic [SLOT_W-1:0] slot_new;
  logic [VAL_W-1:0]  tab_val;
  logic [VAL_W:0]    diff;
  logic [VAL_W:0]    diff_fix;
  logic [FRAC_W-1:0] frac_q;
  logic [FRAC_W:0]   frac_inc;
  logic [FSUM_W-1:0] frac_sum;
  logic [FRAC_W:0]   frac_raw;
  logic [FRAC_W-1:0] frac;

  assign uw        = ucode(step);
  assign cmd_stall = (step != STEP_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign blocked   = draw_valid && draw_stall;
  assign load_out  = uw.out_ld && !blocked;
  assign seed_fix  = (seed == '0) ? VAL_W'(1) : seed;

  always_comb begin
    step_next = step;
    unique case (uw.jump)
      J_NEXT:   step_next = step + STEP_W'(1);
      J_ACTION: begin
        if (cmd_valid) begin
          step_next = cmd.action ? uw.target : step + STEP_W'(1);
        end
      end
      J_LOOP:   step_next = (cnt != '0) ? uw.target : step + STEP_W'(1);
      J_DONE:   step_next = blocked ? step : uw.target;
      J_ALWAYS: step_next = uw.target;
      default:  step_next = STEP_IDLE;
    endcase
  end

  assign mul_op = (uw.mul_sel == MUL_TWO) ? gen_two : gen_one;
  assign mul_k  = (uw.mul_sel == MUL_TWO) ? MUL_B : MUL_A;
  assign red_b  = (uw.g2_ld == G_RED);
  assign red    = mod_fold(prod, red_b ? FOLD_B : FOLD_A, red_b ? MOD_B : MOD_A);

  // The slot estimate from the reciprocal is low by at most one; the limit check fixes it.
  assign est_prod = EPROD_W'(last) * EPROD_W'(SLOT_RECIP);
  assign est_inc  = est + EST_W'(1);
  assign est_lim  = LIM_W'(est_inc) * LIM_W'(SLOT_DIV);
  assign slot_raw = (LIM_W'(last) >= est_lim) ? est_inc : est;
  assign slot_new = (slot_raw > EST_W'(TABLE_DEPTH - 1)) ? SLOT_W'(TABLE_DEPTH - 1)
                                                        : slot_raw[SLOT_W-1:0];

  assign tab_val  = rd_valid ? tab_rdata : '0;
  assign diff     = {1'b0, tab_val} - {1'b0, gen_two};
  assign diff_fix = (diff[VAL_W] || diff == '0) ? diff + MOD_A_LESS : diff;

  always_comb begin
    tab_we    = 1'b0;
    tab_addr  = slot;
    tab_wdata = gen_one;
    unique case (uw.tab_wr)
      TW_WARM: begin
        tab_we    = (cnt < CNT_W'(TABLE_DEPTH));
        tab_addr  = cnt[SLOT_W-1:0];
        tab_wdata = red;
      end
      TW_SLOT: tab_we = 1'b1;
      default: tab_we = 1'b0;
    endcase
  end

  // The modulus sits just below 2^31, so the quotient is the shifted value or one more.
  assign frac_q   = last[VAL_W-1:FRAC_SHIFT];
  assign frac_inc = {1'b0, frac_q} + (FRAC_W + 1)'(1);
  assign frac_sum = FSUM_W'({last[FRAC_SHIFT-1:0], {FRAC_W{1'b0}}})
                  + FSUM_W'(frac_inc) * FSUM_W'(FOLD_A);
  assign frac_raw = (frac_sum[FSUM_W-1:VAL_W] != '0) ? frac_inc : {1'b0, frac_q};
  assign frac     = (frac_raw > (FRAC_W + 1)'(FRAC_MAX)) ? FRAC_MAX : frac_raw[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_IDLE;
      gen_one    <= '0;
      gen_two    <= GEN_TWO_INIT;
      last       <= '0;
      cnt        <= '0;
      tab_valid  <= '0;
      draw_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (uw.g1_ld == G_SEED) begin
        gen_one <= seed_fix;
      end else if (uw.g1_ld == G_RED) begin
        gen_one <= red;
      end
      if (uw.g2_ld == G_SEED) begin
        gen_two <= seed_fix;
      end else if (uw.g2_ld == G_RED) begin
        gen_two <= red;
      end
      if (uw.last_sel == LAST_GEN) begin
        last <= gen_one;
      end else if (uw.last_sel == LAST_DIFF) begin
        last <= diff_fix[VAL_W-1:0];
      end
      if (uw.cnt_op == CNT_INIT) begin
        cnt <= CNT_W'(WARM_STEPS - 1);
      end else if (uw.cnt_op == CNT_DEC) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (tab_we) begin
        tab_valid[tab_addr] <= 1'b1;
      end
      if (load_out) begin
        draw_valid <= 1'b1;
      end else if (!draw_stall) begin
        draw_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed <= cmd.seed_value;
    end
    if (uw.mul_sel != MUL_NONE) begin
      prod <= PROD_W'(mul_op) * PROD_W'(mul_k);
    end
    if (uw.est_ld) begin
      est <= EST_W'(est_prod >> SLOT_SHIFT);
    end
    if (uw.slot_ld) begin
      slot <= slot_new;
    end
    if (load_out) begin
      draw.raw_value <= last;
      draw.fraction  <= frac;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_addr] <= tab_wdata;
    end
    if (uw.rd_en) begin
      tab_rdata <= tab_mem[slot];
      rd_valid  <= tab_valid[slot];
    end
  end

  `ASSERT_NEXT(a_accept_starts_work, clk, rst, accept, step != STEP_IDLE)
  `ASSERT_IMPL(a_draw_in_range, clk, rst, step == STEP_D4, last != '0 && last < MOD_A)
  `ASSERT_IMPL(a_gen_two_reduced, clk, rst, step == STEP_D3, gen_two < MOD_B)
  `ASSERT_IMPL(a_result_from_last_step, clk, rst, $rose(draw_valid), $past(step) == STEP_D4)
  `ASSERT_IMPL(a_warm_count_bound, clk, rst, step == STEP_RS2, cnt <= CNT_W'(WARM_STEPS - 1))

endmodule

`default_nettype wire

FILE: dv/tb_combined_lcg_shuffle_random_core.sv
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_random_core;
  import clsr_pkg::*;

  localparam logic ACT_DRAW   = 1'b0;
  localparam logic ACT_RESEED = 1'b1;

  localparam longint MODULUS_ONE = 2147483563;
  localparam longint MODULUS_TWO = 2147483399;
  localparam longint MULT_ONE    = 40014;
  localparam longint MULT_TWO    = 40692;
  localparam longint QUOT_ONE    = 53668;
  localparam longint QUOT_TWO    = 52774;
  localparam longint REMD_ONE    = 12211;
  localparam longint REMD_TWO    = 3791;
  localparam longint WRAP_ADD    = MODULUS_ONE - 1;
  localparam longint BUCKET_SIZE = 1 + WRAP_ADD / TABLE_DEPTH;
  localparam longint FRAC_CLAMP  = 16777214;
  localparam int     SEED_SKIP   = 8;
  localparam int     N_RANDOM    = 2000;
  localparam int     TAIL_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 1000000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cmd_valid = 1'b0;
  logic   cmd_stall;
  cmd_t   cmd = '0;
  logic   draw_valid;
  logic   draw_stall = 1'b0;
  draw_t  draw;

  longint lcg_one;
  longint lcg_two;
  longint prev_out;
  longint shuffle_mem [TABLE_DEPTH];

  draw_t  expected_draws[$];
  int     fail_count = 0;
  bit     idle_on = 1'b0;
  int     hold_request = 0;
  int     hold_left = 0;
  int     rx_wait = 0;
  longint cycle_count = 0;

  combined_lcg_shuffle_random_core dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .draw_valid (draw_valid),
    .draw_stall (draw_stall),
    .draw       (draw)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint schrage_step(input longint x, input longint mul, input longint quo,
                                          input longint rem, input longint modulus);
    longint k;
    longint y;
    k = x / quo;
    y = mul * (x - k * quo) - k * rem;
    if (y < 0) y += modulus;
    return y;
  endfunction

  function automatic void clear_generator();
    lcg_one  = 0;
    lcg_two  = 123456789;
    prev_out = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) shuffle_mem[i] = 0;
  endfunction

  function automatic draw_t next_draw(input cmd_t c);
    draw_t  d;
    longint s;
    longint slot;
    longint frac;
    if (c.action == ACT_RESEED) begin
      s = longint'(c.seed_value);
      if (s < 1) s = 1;
      lcg_one = s;
      lcg_two = s;
      for (int step = TABLE_DEPTH + SEED_SKIP - 1; step >= 0; step--) begin
        lcg_one = schrage_step(lcg_one, MULT_ONE, QUOT_ONE, REMD_ONE, MODULUS_ONE);
        if (step < TABLE_DEPTH) shuffle_mem[step] = lcg_one;
      end
      prev_out = shuffle_mem[0];
    end
    lcg_one = schrage_step(lcg_one, MULT_ONE, QUOT_ONE, REMD_ONE, MODULUS_ONE);
    lcg_two = schrage_step(lcg_two, MULT_TWO, QUOT_TWO, REMD_TWO, MODULUS_TWO);
    slot = prev_out / BUCKET_SIZE;
    if (slot < 0) slot = 0;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    prev_out = shuffle_mem[slot] - lcg_two;
    shuffle_mem[slot] = lcg_one;
    if (prev_out < 1) prev_out += WRAP_ADD;
    frac = (prev_out << 24) / MODULUS_ONE;
    if (frac > FRAC_CLAMP) frac = FRAC_CLAMP;
    d.raw_value = prev_out[VAL_W-1:0];
    d.fraction  = frac[FRAC_W-1:0];
    return d;
  endfunction

  task automatic send_cmd(input logic act, input logic [VAL_W-1:0] seed);
    int   gap;
    cmd_t c;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    c.action     = act;
    c.seed_value = seed;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    expected_draws.push_back(next_draw(c));
  endtask

  function automatic logic [VAL_W-1:0] random_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VAL_W'($urandom_range(32'd2147483560, 32'd2147483647));
      2:       return VAL_W'($urandom_range(0, 15));
      3:       return VAL_W'($urandom_range(32'd2147483390, 32'd2147483410));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      draw_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      if (draw_valid && !draw_stall) begin
        rx_wait = idle_on ? $urandom_range(0, 7) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      draw_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    draw_t exp_d;
    if (!rst && draw_valid && !draw_stall) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected draw transaction: raw_value %0d fraction %0d",
               draw.raw_value, draw.fraction);
        fail_count++;
      end else begin
        exp_d = expected_draws.pop_front();
        if (draw.raw_value !== exp_d.raw_value) begin
          $error("raw_value mismatch: expected %0d, actual %0d", exp_d.raw_value,
                 draw.raw_value);
          fail_count++;
        end
        if (draw.fraction !== exp_d.fraction) begin
          $error("fraction mismatch: expected %0d, actual %0d", exp_d.fraction,
                 draw.fraction);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_combined_lcg_shuffle_random_core: FAIL");
      $finish;
    end
  end

  task automatic test_unseeded_draws();
    idle_on = 1'b0;
    repeat (4) send_cmd(ACT_DRAW, VAL_W'($urandom));
  endtask

  task automatic test_seed_extremes();
    logic [VAL_W-1:0] seeds [10];
    seeds = '{31'd0, 31'd1, 31'h7FFFFFFF, 31'd2147483563, 31'd2147483562,
              31'd2147483564, 31'd2147483399, 31'd2147483400, 31'h2AAAAAAA, 31'h55555555};
    idle_on = 1'b1;
    foreach (seeds[i]) begin
      send_cmd(ACT_RESEED, seeds[i]);
      send_cmd(ACT_DRAW, ~seeds[i]);
    end
  endtask

  task automatic test_output_backpressure();
    idle_on      = 1'b0;
    hold_request = 400;
    send_cmd(ACT_RESEED, VAL_W'($urandom));
    repeat (30) send_cmd(ACT_DRAW, VAL_W'($urandom));
  endtask

  task automatic test_random_draws();
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 250 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) send_cmd(ACT_RESEED, random_seed());
      else send_cmd(ACT_DRAW, VAL_W'($urandom));
    end
  endtask

  initial begin
    clear_generator();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_unseeded_draws();
    test_seed_extremes();
    test_output_backpressure();
    test_random_draws();
    cmd_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_combined_lcg_shuffle_random_core: PASS");
    end else begin
      $display("tb_combined_lcg_shuffle_random_core: FAIL");
    end
    $finish;
  end

endmodule
